/* rtl/core/lz78_phrase_encoder_defines.svh */
// Assertion macros shared by the LZ78 phrase encoder RTL.
`ifndef LZ78_PHRASE_ENCODER_DEFINES_SVH
`define LZ78_PHRASE_ENCODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LZ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define LZ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/lz78_pkg.sv */
// Package with the types and constants of the LZ78 phrase encoder.
`default_nettype none

package lz78_pkg;

    localparam int SYM_W      = 8;
    localparam int PHRASE_W   = 12;
    localparam int LIMIT_W    = 13;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_DICT_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET    = 13'd4096;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK
    } lz_state_t;

    typedef struct packed {
        logic [SYM_W-1:0]    symbol;
        logic [PHRASE_W-1:0] phrase;
        logic                full;
    } lz_result_t;

endpackage

`default_nettype wire

/* rtl/core/lz78_ifs.sv */
// Handshake interfaces for the text byte channel and the code channel.
`default_nettype none

interface lz78_byte_if import lz78_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface lz78_code_if import lz78_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SYM_W-1:0]    out_symbol;
    logic [PHRASE_W-1:0] out_phrase;
    logic                dict_full;

    modport source (output valid, output out_symbol, output out_phrase, output dict_full,
                    input ready);
    modport sink (input valid, input out_symbol, input out_phrase, input dict_full,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/lz78_phrase_encoder.sv */
// Top level of the LZ78 phrase encoder: APB registers, dictionary walk, and code register.
// Bytes are taken only in idle, so a new byte waits until all probes of the last one are done.
// A code is emitted only on a probe miss; code valid is registered from that miss.
// Probes share the single table read port; a miss also waits while a code beat is unaccepted.
// After reset the child table is swept clear, with text ready held low;
// APB writes are taken throughout.
`default_nettype none

module lz78_phrase_encoder import lz78_pkg::*; #(
    parameter int DICT_SIZE = 4096
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready,
    lz78_byte_if.sink                  text,
    lz78_code_if.source                code
);

    logic [LIMIT_W-1:0] dict_limit;
    logic               emit_valid;
    lz_result_t         emit;
    logic               room;
    logic               out_valid_reg;
    logic               out_valid_next;
    lz_result_t         res_reg;

    lz78_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .dict_limit (dict_limit)
    );

    lz78_probe #(
        .DICT_SIZE (DICT_SIZE)
    ) u_probe (
        .clk        (clk),
        .rst_n      (rst_n),
        .dict_limit (dict_limit),
        .text       (text),
        .room       (room),
        .emit_valid (emit_valid),
        .emit       (emit)
    );

    assign room = !out_valid_reg || code.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (code.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid)
        begin
            res_reg <= emit;
        end
    end

    assign code.valid      = out_valid_reg;
    assign code.out_symbol = res_reg.symbol;
    assign code.out_phrase = res_reg.phrase;
    assign code.dict_full  = res_reg.full;

endmodule

`default_nettype wire

/* rtl/core/lz78_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lz78_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/core/lz78_apb_regs.sv */
// APB register block holding the dictionary limit.
`default_nettype none

module lz78_apb_regs import lz78_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready,
    output      logic [LIMIT_W-1:0]    dict_limit
);

    logic [LIMIT_W-1:0]   limit_reg;
    logic [LIMIT_W-1:0]   limit_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        limit_next = limit_reg;
        prdata     = '0;
        unique case (reg_idx)
            REG_DICT_LIMIT:
            begin
                prdata = APB_DATA_W'(limit_reg);
                if (wr_en)
                begin
                    limit_next = pwdata[LIMIT_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign dict_limit = limit_reg;

endmodule

`default_nettype wire

/* rtl/core/lz78_probe.sv */
// Dictionary walk: hashed child table, probe sequencer, and phrase id allocation.
`default_nettype none

`include "lz78_phrase_encoder_defines.svh"

module lz78_probe import lz78_pkg::*; #(
    parameter int DICT_SIZE = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [LIMIT_W-1:0] dict_limit,
    lz78_byte_if.sink               text,
    input  wire logic               room,
    output      logic               emit_valid,
    output      lz_result_t         emit
);

    localparam int IDW    = $clog2(DICT_SIZE);
    localparam int NW     = $clog2(DICT_SIZE + 1);
    localparam int HAW    = IDW + 1;
    localparam int HDEPTH = 2 ** HAW;
    localparam int KEYW   = SYM_W + IDW;
    localparam int SLOTW  = 1 + KEYW + IDW;
    localparam int NFOLD  = (KEYW + HAW - 1) / HAW;
    localparam int CW     = (NW > LIMIT_W) ? NW : LIMIT_W;

    lz_state_t          state_reg;
    lz_state_t          state_next;
    logic [IDW-1:0]     cur_reg;
    logic [IDW-1:0]     cur_next;
    logic [NW-1:0]      next_id_reg;
    logic [NW-1:0]      next_id_next;
    logic [HAW-1:0]     clr_reg;
    logic [HAW-1:0]     clr_next;
    logic [SYM_W-1:0]   sym_reg;
    logic [HAW-1:0]     probe_reg;

    logic               ram_we;
    logic [HAW-1:0]     ram_waddr;
    logic [SLOTW-1:0]   ram_wdata;
    logic               ram_re;
    logic [HAW-1:0]     ram_raddr;
    logic [SLOTW-1:0]   ram_rdata;

    logic               slot_used;
    logic [KEYW-1:0]    slot_key;
    logic [IDW-1:0]     slot_id;
    logic               hit;
    logic               miss;
    logic               full;
    logic               accept;

    function automatic logic [HAW-1:0] hash_fn(input logic [IDW-1:0] node,
                                               input logic [SYM_W-1:0] sym);
        logic [KEYW-1:0] key;
        logic [HAW-1:0]  acc;
        key = {sym, node};
        acc = '0;
        for (int i = 0; i < NFOLD; i++)
        begin
            acc = acc ^ HAW'(key >> (i * HAW));
        end
        return acc;
    endfunction

    lz78_ram #(
        .WIDTH (SLOTW),
        .DEPTH (HDEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign slot_used = ram_rdata[SLOTW-1];
    assign slot_key  = ram_rdata[SLOTW-2 -: KEYW];
    assign slot_id   = ram_rdata[IDW-1:0];
    assign hit       = (state_reg == ST_CHECK) && slot_used && (slot_key == {sym_reg, cur_reg});
    assign miss      = (state_reg == ST_CHECK) && !slot_used;
    assign full      = (next_id_reg >= NW'(DICT_SIZE)) ||
                       (CW'(next_id_reg) >= CW'(dict_limit));
    assign accept    = text.valid && text.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == HAW'(HDEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (text.valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (hit || (miss && room))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        text.ready = 1'b0;
        ram_re     = 1'b0;
        ram_raddr  = probe_reg + HAW'(1);
        ram_we     = 1'b0;
        ram_waddr  = probe_reg;
        ram_wdata  = {1'b1, sym_reg, cur_reg, IDW'(next_id_reg)};
        emit_valid = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                text.ready = 1'b1;
                ram_re     = text.valid;
                ram_raddr  = hash_fn(cur_reg, text.text_byte);
            end
            ST_CHECK:
            begin
                ram_re     = slot_used && !hit;
                emit_valid = miss && room;
                ram_we     = miss && room && !full;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    assign emit.symbol = sym_reg;
    assign emit.phrase = PHRASE_W'(cur_reg);
    assign emit.full   = full;

    always_comb
    begin
        cur_next     = cur_reg;
        next_id_next = next_id_reg;
        clr_next     = clr_reg;
        if (state_reg == ST_CLEAR)
        begin
            clr_next = clr_reg + HAW'(1);
        end
        if (hit)
        begin
            cur_next = slot_id;
        end
        else if (emit_valid)
        begin
            cur_next = '0;
            if (!full)
            begin
                next_id_next = next_id_reg + NW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            cur_reg     <= '0;
            next_id_reg <= NW'(1);
            clr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            next_id_reg <= next_id_next;
            clr_reg     <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sym_reg <= text.text_byte;
        end
        if (ram_re)
        begin
            probe_reg <= ram_raddr;
        end
    end

    `LZ_ASSERT_NEXT(a_id_advance, emit_valid && !full, next_id_reg == $past(next_id_reg) + NW'(1), "phrase id did not advance after an insert")
    `LZ_ASSERT_NEXT(a_hit_walk, hit, (cur_reg == $past(slot_id)) && (state_reg == ST_IDLE), "walk did not move to the matched child")
    `LZ_ASSERT_NOW(a_write_empty, (state_reg == ST_CHECK) && ram_we, !slot_used && emit_valid, "insert into an occupied slot")
    `LZ_ASSERT_NOW(a_id_bound, 1'b1, next_id_reg <= NW'(DICT_SIZE), "phrase id past the dictionary size")

endmodule

`default_nettype wire
